FILE: rtl/gss_pkg.sv
package gss_pkg;

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 16;
    localparam int ROW_W     = 6;
    localparam int COL_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int WORD_W    = 32;
    localparam int HEAD_DEPTH = 2 * GRID_COLS;
    localparam int ROLL_DEPTH = 3 * GRID_COLS;
    localparam int HEAD_AW   = $clog2(HEAD_DEPTH);
    localparam int ROLL_AW   = $clog2(ROLL_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_FEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KILL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIFFU = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIFFV = 2'd3;

    // multiply operand selects for the shared multiplier
    typedef enum logic [2:0] {
        MUL_UV,
        MUL_UVV,
        MUL_DU,
        MUL_DV,
        MUL_FU,
        MUL_FKV
    } mul_op_t;

    typedef struct packed {
        logic signed [63:0] acc_u;
        logic signed [63:0] acc_v;
    } gss_acc_t;

endpackage

FILE: rtl/gray_scott_stencil_step_core.sv
// Gray-Scott stencil step, one cell per input word, results one row behind.
// Pipeline: after a word of row 2 or later is taken, m_tvalid rises after setup,
//   five RAM reads, six multiplier passes and a finish step.
// Throughput: s_tready stays low from a word of row 2 or later until its result is taken;
//   rows 0 and 1 go one per cycle; the final word adds 2*GRID_COLS drain results.
// Reset: aresetn, synchronous, active low; clears counters and control, loads config defaults.
module gray_scott_stencil_step_core
    import gss_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // cell_u[15:0], cell_v[31:16]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // row_index[5:0], col_index[9:6],
                                            // next_u[25:10], next_v[41:26], pad
    output logic                 m_tlast,   // grid_done
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_EMIT_SETUP, S_RD, S_MUL, S_FIN, S_OUT
    } state_t;

    state_t state_reg;

    logic [15:0] feed_reg, kill_reg, diffu_reg, diffv_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;

    // emission job
    logic [ROW_W-1:0] e_row_reg;
    logic [COL_W-1:0] e_col_reg;
    logic [1:0]       phase_reg;   // 0 normal, 1 last row drain, 2 row 0 drain
    logic             tail_reg;    // drain follows this emit
    logic [2:0]       rd_reg;      // read step: 0 mid,1 left,2 right,3 up,4 down
    logic [2:0]       mstep_reg;
    logic             pipe_reg;

    logic signed [15:0] cu_reg, cv_reg;
    logic signed [19:0] lu_reg, lv_reg;
    logic signed [51:0] uvv_reg;
    logic [31:0] rd_word;

    // RAM ports: rolling and head rows share one read address cycle
    logic            roll_we, head_we;
    logic [ROLL_AW-1:0] roll_waddr, roll_raddr;
    logic [HEAD_AW-1:0] head_waddr, head_raddr;
    logic [31:0]     roll_rdata, head_rdata;
    logic            rd_head_reg, rd_head;

    logic in_acc;
    assign in_acc = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    // 4 = 1 mod 3, so sum the base-4 digits and fold
    function automatic logic [1:0] mod3(input logic [ROW_W-1:0] r);
        logic [3:0] s;
        s = 4'(r[1:0]) + 4'(r[3:2]) + 4'(r[5:4]);
        if (s >= 4'd6) s = s - 4'd6;
        if (s >= 4'd3) s = s - 4'd3;
        return s[1:0];
    endfunction

    assign roll_we    = in_acc;
    assign roll_waddr = ROLL_AW'(mod3(row_reg) * GRID_COLS + col_reg);
    assign head_we    = in_acc && (row_reg < 2);
    assign head_waddr = HEAD_AW'(row_reg[0] * GRID_COLS + col_reg);

    gss_ram #(.WIDTH(WORD_W), .DEPTH(ROLL_DEPTH)) u_roll (
        .aclk(aclk), .we(roll_we), .waddr(roll_waddr), .wdata(s_tdata),
        .raddr(roll_raddr), .rdata(roll_rdata));
    gss_ram #(.WIDTH(WORD_W), .DEPTH(HEAD_DEPTH)) u_head (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(s_tdata),
        .raddr(head_raddr), .rdata(head_rdata));

    // neighbour address
    logic [COL_W-1:0] cl, cr, rc;
    logic [ROW_W-1:0] rr;
    logic             use_head;
    assign cl = (e_col_reg == 0) ? COL_W'(GRID_COLS - 1) : e_col_reg - 1'b1;
    assign cr = (e_col_reg == COL_W'(GRID_COLS - 1)) ? '0 : e_col_reg + 1'b1;

    always_comb begin
        rc = e_col_reg;
        rr = e_row_reg;
        unique case (rd_reg)
            3'd1: rc = cl;
            3'd2: rc = cr;
            3'd3: rr = (e_row_reg == 0) ? ROW_W'(GRID_ROWS - 1) : e_row_reg - 1'b1;
            3'd4: rr = (e_row_reg == ROW_W'(GRID_ROWS - 1)) ? '0 : e_row_reg + 1'b1;
            default: ;
        endcase
        use_head = (rr < 2) && (phase_reg != 2'd0);
    end
    assign rd_head    = use_head;
    assign roll_raddr = ROLL_AW'(mod3(rr) * GRID_COLS + rc);
    assign head_raddr = HEAD_AW'(rr[0] * GRID_COLS + rc);
    assign rd_word    = rd_head_reg ? head_rdata : roll_rdata;

    // shared multiplier operand selection
    logic signed [33:0] op_a;
    logic signed [17:0] op_b;
    logic               mul_en, acc_en, clr;
    logic signed [51:0] prod;
    gss_acc_t           acc;

    always_comb begin
        op_a = '0; op_b = '0;
        unique case (mstep_reg)
            3'd0: begin op_a = 34'(cv_reg); op_b = 18'(cv_reg); end
            // v*v straight from the product register
            3'd1: begin op_a = prod[33:0]; op_b = 18'(cu_reg); end
            3'd2: begin op_a = 34'(lu_reg); op_b = 18'($signed({1'b0, diffu_reg})); end
            3'd3: begin op_a = 34'(lv_reg); op_b = 18'($signed({1'b0, diffv_reg})); end
            3'd4: begin op_a = 34'(18'sd16384 - 18'(cu_reg));
                        op_b = 18'($signed({1'b0, feed_reg})); end
            3'd5: begin op_a = 34'(cv_reg);
                        op_b = $signed({1'b0, 17'(feed_reg) + 17'(kill_reg)}); end
            default: ;
        endcase
    end
    // product of step k is summed at step k+1
    logic [2:0] pstep_reg;
    logic signed [63:0] uvv4;
    assign mul_en = (state_reg == S_MUL);
    assign acc_en = (state_reg == S_MUL || state_reg == S_FIN) && pipe_reg
                    && pstep_reg >= 3'd2;
    assign clr    = (state_reg == S_EMIT_SETUP);
    assign uvv4   = 64'(uvv_reg) <<< 2;

    logic mac_v, mac_neg;
    logic [5:0] mac_sh;
    always_comb begin
        mac_v = 1'b0; mac_neg = 1'b0; mac_sh = 6'd14;
        unique case (pstep_reg)
            3'd3: mac_v = 1'b1;
            3'd5: begin mac_v = 1'b1; mac_neg = 1'b1; end
            default: ;
        endcase
    end

    gss_mac u_mac (
        .aclk(aclk), .clr(clr), .mul_en(mul_en), .op_a(op_a), .op_b(op_b),
        .acc_en(acc_en), .acc_sel_v(mac_v), .acc_neg(mac_neg), .acc_shift(mac_sh),
        .prod(prod), .acc(acc));

    // final rounding and saturation
    logic signed [63:0] du, dv;
    logic signed [33:0] nu, nv;
    logic [15:0] su, sv;
    assign du = acc.acc_u - uvv4 + 64'sd536870912;
    assign dv = acc.acc_v + uvv4 + 64'sd536870912;
    assign nu = 34'(cu_reg) + 34'(du >>> 30);
    assign nv = 34'(cv_reg) + 34'(dv >>> 30);
    assign su = (nu > 34'sd32767) ? 16'h7fff : (nu < -34'sd32768) ? 16'h8000 : nu[15:0];
    assign sv = (nv > 34'sd32767) ? 16'h7fff : (nv < -34'sd32768) ? 16'h8000 : nv[15:0];

    logic [47:0] m_data_reg;
    logic        m_valid_reg, m_last_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    logic last_in;
    assign last_in = (row_reg == ROW_W'(GRID_ROWS - 1)) && (col_reg == COL_W'(GRID_COLS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            feed_reg <= 16'd2621; kill_reg <= 16'd3867;
            diffu_reg <= 16'd6554; diffv_reg <= 16'd3277;
            row_reg <= '0; col_reg <= '0;
            m_valid_reg <= 1'b0;
            phase_reg <= '0; tail_reg <= 1'b0;
            rd_reg <= '0; mstep_reg <= '0; pstep_reg <= '0; pipe_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_FEED:  feed_reg  <= cfg_data;
                    REG_KILL:  kill_reg  <= cfg_data;
                    REG_DIFFU: diffu_reg <= cfg_data;
                    REG_DIFFV: diffv_reg <= cfg_data;
                    default: ;
                endcase
            end
            rd_head_reg <= rd_head;
            unique case (state_reg)
                S_IDLE: if (in_acc) begin
                    if (col_reg == COL_W'(GRID_COLS - 1)) begin
                        col_reg <= '0;
                        row_reg <= last_in ? '0 : row_reg + 1'b1;
                    end else begin
                        col_reg <= col_reg + 1'b1;
                    end
                    e_row_reg <= row_reg - 1'b1;
                    e_col_reg <= col_reg;
                    phase_reg <= 2'd0;
                    tail_reg  <= last_in;
                    if (row_reg >= 2) state_reg <= S_EMIT_SETUP;
                end
                S_EMIT_SETUP: begin
                    rd_reg <= '0; mstep_reg <= '0; pstep_reg <= '0; pipe_reg <= 1'b0;
                    lu_reg <= '0; lv_reg <= '0;
                    state_reg <= S_RD;
                end
                S_RD: begin
                    // data for address issued last cycle
                    if (pipe_reg) begin
                        if (pstep_reg == 3'd0) begin
                            cu_reg <= rd_word[15:0]; cv_reg <= rd_word[31:16];
                            lu_reg <= lu_reg - (20'(signed'(rd_word[15:0])) <<< 2);
                            lv_reg <= lv_reg - (20'(signed'(rd_word[31:16])) <<< 2);
                        end else begin
                            lu_reg <= lu_reg + 20'(signed'(rd_word[15:0]));
                            lv_reg <= lv_reg + 20'(signed'(rd_word[31:16]));
                        end
                    end
                    pstep_reg <= rd_reg;
                    pipe_reg  <= (rd_reg != 3'd5);
                    if (rd_reg == 3'd5) begin
                        state_reg <= S_MUL; mstep_reg <= '0;
                    end else begin
                        rd_reg <= rd_reg + 1'b1;
                    end
                end
                S_MUL: begin
                    if (pipe_reg && pstep_reg == 3'd1) uvv_reg <= prod;
                    pstep_reg <= mstep_reg;
                    pipe_reg  <= 1'b1;
                    if (mstep_reg == 3'd5) state_reg <= S_FIN;
                    else mstep_reg <= mstep_reg + 1'b1;
                end
                S_FIN: begin
                    pipe_reg <= 1'b0;
                    if (!pipe_reg) begin
                        m_data_reg <= {6'd0, sv, su, e_col_reg, e_row_reg};
                        m_last_reg <= (phase_reg == 2'd2) &&
                                      (e_col_reg == COL_W'(GRID_COLS - 1));
                        m_valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: if (m_tready) begin
                    m_valid_reg <= 1'b0;
                    if (tail_reg) begin
                        tail_reg <= 1'b0; phase_reg <= 2'd1;
                        e_row_reg <= ROW_W'(GRID_ROWS - 1); e_col_reg <= '0;
                        state_reg <= S_EMIT_SETUP;
                    end else if (phase_reg != 2'd0) begin
                        if (e_col_reg != COL_W'(GRID_COLS - 1)) begin
                            e_col_reg <= e_col_reg + 1'b1;
                            state_reg <= S_EMIT_SETUP;
                        end else if (phase_reg == 2'd1) begin
                            phase_reg <= 2'd2; e_row_reg <= '0; e_col_reg <= '0;
                            state_reg <= S_EMIT_SETUP;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/gss_ram.sv
module gss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/gss_mac.sv
// shared signed multiply-accumulate: registered product, then accumulate
module gss_mac
    import gss_pkg::*;
(
    input  logic               aclk,
    input  logic               clr,
    input  logic               mul_en,
    input  logic signed [33:0] op_a,
    input  logic signed [17:0] op_b,
    input  logic               acc_en,
    input  logic               acc_sel_v,
    input  logic               acc_neg,
    input  logic [5:0]         acc_shift,
    output logic signed [51:0] prod,
    output gss_acc_t           acc
);

    logic signed [51:0] prod_reg;
    logic signed [63:0] term;

    assign prod = prod_reg;
    assign term = (64'(prod_reg) <<< acc_shift);

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= op_a * op_b;
        end
        if (clr) begin
            acc.acc_u <= '0;
            acc.acc_v <= '0;
        end else if (acc_en) begin
            if (acc_sel_v) begin
                acc.acc_v <= acc_neg ? acc.acc_v - term : acc.acc_v + term;
            end else begin
                acc.acc_u <= acc_neg ? acc.acc_u - term : acc.acc_u + term;
            end
        end
    end

endmodule
